FILE: hw/rtl/dblp_pkg.sv
// dblp_pkg: shared types and constants of the delimited byte list parser
// no dependencies; used by every module of the block
package dblp_pkg;

    // character classes sent from the classifier to the field engine
    typedef enum logic [1:0] {
        KIND_DIGIT,
        KIND_DELIM,
        KIND_TERM,
        KIND_BAD
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
    } t_token;

    typedef struct packed {
        logic [7:0] delimiter_char;
        logic [1:0] radix_mode;
        logic [7:0] expected_count;
    } t_cfg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic [7:0] field_index;
        logic       line_end;
        logic       line_ok;
    } t_result;

    // radix codes; the fourth code behaves as decimal
    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_DELIMITER = 2'd0;
    localparam logic [1:0] REG_RADIX     = 2'd1;
    localparam logic [1:0] REG_EXPECTED  = 2'd2;

    localparam logic [7:0] CHAR_NUL = 8'd0;
    localparam logic [7:0] CHAR_LF  = 8'd10;

    localparam logic [7:0] RST_DELIMITER = 8'd44;
    localparam logic [1:0] RST_RADIX     = 2'd1;
    localparam logic [7:0] RST_EXPECTED  = 8'd1;

    localparam logic [9:0] BYTE_MAX = 10'd255;

endpackage

FILE: hw/rtl/dblp_in_if.sv
// dblp_in_if: character channel of the parser, valid/ready handshake
// no dependencies
interface dblp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

FILE: hw/rtl/dblp_out_if.sv
// dblp_out_if: result channel of the parser, valid/ready handshake
// no dependencies
interface dblp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic [7:0] field_index;
    logic       line_end;
    logic       line_ok;

    modport source (output valid, output byte_value, output field_index,
                    output line_end, output line_ok, input ready);
    modport sink   (input valid, input byte_value, input field_index,
                    input line_end, input line_ok, output ready);
endinterface

FILE: hw/rtl/delimited_byte_list_parser_top.sv
// delimited_byte_list_parser_top: top level of the delimited byte list parser
// depends on dblp_pkg, dblp_in_if, dblp_out_if, dblp_front, dblp_queue, dblp_back
// a character is written into the token queue, and its result into the result register that drives o_res
// throughput: one character per cycle while the token queue has room
// results that wait on o_res do not block input until the token queue fills
// reset (synchronous, active low) clears line state, queue and output valid,
// and loads delimiter 44, decimal radix and an expected count of one
module delimited_byte_list_parser_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    dblp_in_if.sink            i_char,
    dblp_out_if.source         o_res,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data
);

    // configuration registers: user writes only while parser is idle, not enforced
    dblp_pkg::t_cfg r_cfg;

    // classifier to queue
    logic             front_push;
    dblp_pkg::t_token front_token;

    // queue to field engine
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    dblp_pkg::t_token q_token;

    dblp_pkg::t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter_char <= dblp_pkg::RST_DELIMITER;
            r_cfg.radix_mode     <= dblp_pkg::RST_RADIX;
            r_cfg.expected_count <= dblp_pkg::RST_EXPECTED;
        end else if (i_cfg_we) begin
            // an index past the last register is dropped
            unique case (i_cfg_idx)
                dblp_pkg::REG_DELIMITER: r_cfg.delimiter_char <= i_cfg_data;
                dblp_pkg::REG_RADIX:     r_cfg.radix_mode     <= i_cfg_data[1:0];
                dblp_pkg::REG_EXPECTED:  r_cfg.expected_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front: classify each character as it is transferred in
    dblp_front u_front (
        .i_valid     (i_char.valid),
        .i_char_code (i_char.char_code),
        .i_full      (q_full),
        .i_cfg       (r_cfg),
        .o_ready     (i_char.ready),
        .o_push      (front_push),
        .o_token     (front_token)
    );

    // short queue so each side can stall on its own
    dblp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_token (front_token),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_token (q_token)
    );

    // back: field accumulation, checks and the registered result
    dblp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_tok_valid (q_valid),
        .i_token     (q_token),
        .o_pop       (q_pop),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_result    (result)
    );

    assign o_res.byte_value  = result.byte_value;
    assign o_res.field_index = result.field_index;
    assign o_res.line_end    = result.line_end;
    assign o_res.line_ok     = result.line_ok;

endmodule

FILE: hw/rtl/dblp_front.sv
// dblp_front: classifies each incoming character for the current radix and delimiter
// depends on dblp_pkg
module dblp_front (
    input  logic              i_valid,
    input  logic [7:0]        i_char_code,
    input  logic              i_full,
    input  dblp_pkg::t_cfg    i_cfg,
    output logic              o_ready,
    output logic              o_push,
    output dblp_pkg::t_token  o_token
);

    logic is_dec;
    logic is_bin;
    logic is_lower;
    logic is_upper;

    always_comb begin
        is_dec   = (i_char_code >= 8'h30) && (i_char_code <= 8'h39);
        is_bin   = (i_char_code == 8'h30) || (i_char_code == 8'h31);
        is_lower = (i_char_code >= 8'h61) && (i_char_code <= 8'h66);
        is_upper = (i_char_code >= 8'h41) && (i_char_code <= 8'h46);

        o_token.digit = i_char_code[3:0];
        // digit test first, then delimiter, then terminator
        if ((i_cfg.radix_mode == dblp_pkg::RADIX_BIN) ? is_bin : is_dec) begin
            o_token.kind = dblp_pkg::KIND_DIGIT;
        end else if ((i_cfg.radix_mode == dblp_pkg::RADIX_HEX) && (is_lower || is_upper)) begin
            o_token.kind  = dblp_pkg::KIND_DIGIT;
            o_token.digit = 4'(i_char_code[3:0] + 4'd9);
        end else if (i_char_code == i_cfg.delimiter_char) begin
            o_token.kind = dblp_pkg::KIND_DELIM;
        end else if ((i_char_code == dblp_pkg::CHAR_NUL) || (i_char_code == dblp_pkg::CHAR_LF)) begin
            o_token.kind = dblp_pkg::KIND_TERM;
        end else begin
            o_token.kind = dblp_pkg::KIND_BAD;
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule

FILE: hw/rtl/dblp_queue.sv
// dblp_queue: short token queue between classifier and field engine
// depends on dblp_pkg
module dblp_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dblp_pkg::t_token  i_token,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output dblp_pkg::t_token  o_token
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    dblp_pkg::t_token r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : PW'(r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : PW'(r_rd_ptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = CW'(r_count + 1'b1);
        end else if (!i_push && i_pop) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

FILE: hw/rtl/dblp_back.sv
// dblp_back: field engine; keeps digit/field counts, value and error flag, drives results
// depends on dblp_pkg
module dblp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dblp_pkg::t_cfg    i_cfg,
    input  logic              i_tok_valid,
    input  dblp_pkg::t_token  i_token,
    output logic              o_pop,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output dblp_pkg::t_result o_result
);

    logic [1:0]        r_digit_count, n_digit_count;
    logic [7:0]        r_field_count, n_field_count;
    logic [9:0]        r_acc, n_acc;
    logic              r_err, n_err;
    logic              r_out_valid, n_out_valid;
    dblp_pkg::t_result r_out, n_out;

    logic       emit;
    logic [1:0] limit;
    logic [9:0] acc_scaled;
    logic       is_decimal;
    logic       good;
    logic [8:0] next_fields;

    assign o_pop       = i_tok_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        is_decimal  = (i_cfg.radix_mode != dblp_pkg::RADIX_BIN) &&
                      (i_cfg.radix_mode != dblp_pkg::RADIX_HEX);
        unique case (i_cfg.radix_mode)
            dblp_pkg::RADIX_BIN: begin
                limit      = 2'd1;
                acc_scaled = {r_acc[8:0], 1'b0};
            end
            dblp_pkg::RADIX_HEX: begin
                limit      = 2'd2;
                acc_scaled = {r_acc[5:0], 4'b0};
            end
            default: begin
                limit      = 2'd3;
                acc_scaled = 10'({r_acc[6:0], 3'b0} + {r_acc[8:0], 1'b0});
            end
        endcase
        good        = (r_digit_count != 2'd0) && !(is_decimal && (r_acc > dblp_pkg::BYTE_MAX));
        next_fields = {1'b0, r_field_count} + 9'd1;

        n_digit_count = r_digit_count;
        n_field_count = r_field_count;
        n_acc         = r_acc;
        n_err         = r_err;
        n_out         = r_out;
        emit          = 1'b0;

        if (o_pop) begin
            unique case (i_token.kind)
                dblp_pkg::KIND_DIGIT: begin
                    if (!r_err) begin
                        if (r_digit_count >= limit) begin
                            n_err = 1'b1;
                        end else begin
                            n_digit_count = 2'(r_digit_count + 2'd1);
                            n_acc         = 10'(acc_scaled + {6'd0, i_token.digit});
                        end
                    end
                end
                dblp_pkg::KIND_DELIM: begin
                    if (!r_err) begin
                        if (!good || (next_fields >= {1'b0, i_cfg.expected_count})) begin
                            n_err = 1'b1;
                        end else begin
                            emit                  = 1'b1;
                            n_out.byte_value      = r_acc[7:0];
                            n_out.field_index     = r_field_count;
                            n_out.line_end        = 1'b0;
                            n_out.line_ok         = 1'b1;
                            n_field_count         = next_fields[7:0];
                            n_digit_count         = 2'd0;
                            n_acc                 = 10'd0;
                        end
                    end
                end
                dblp_pkg::KIND_TERM: begin
                    emit              = 1'b1;
                    n_out.line_ok     = !r_err && good &&
                                        (next_fields == {1'b0, i_cfg.expected_count});
                    n_out.byte_value  = n_out.line_ok ? r_acc[7:0] : 8'd0;
                    n_out.field_index = r_field_count;
                    n_out.line_end    = 1'b1;
                    n_digit_count     = 2'd0;
                    n_field_count     = 8'd0;
                    n_acc             = 10'd0;
                    n_err             = 1'b0;
                end
                default: begin
                    n_err = 1'b1;
                end
            endcase
        end

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= 2'd0;
            r_field_count <= 8'd0;
            r_acc         <= 10'd0;
            r_err         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_digit_count <= n_digit_count;
            r_field_count <= n_field_count;
            r_acc         <= n_acc;
            r_err         <= n_err;
            r_out_valid   <= n_out_valid;
        end
        r_out <= n_out;
    end

    a_field_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.line_end) |-> r_out.line_ok)
        else $error("field result without ok flag");
    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_token.kind == dblp_pkg::KIND_TERM)) |=>
        (r_field_count == 8'd0) && (r_digit_count == 2'd0) && !r_err)
        else $error("terminator did not clear line state");
    a_quiet_after_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_err && (i_token.kind != dblp_pkg::KIND_TERM)) |-> !emit)
        else $error("result emitted after error");
    a_digit_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digit_count <= limit)
        else $error("digit count above radix limit");

endmodule
